### sv/cde_pkg.sv
// ----------------------------------------------------------------------------
// cde_pkg: shared types and constants of the circular deque
// Sizes of the cell row, request and status codes, and the cell control word.
// ----------------------------------------------------------------------------
package cde_pkg;

  localparam int DEPTH  = 128;
  localparam int DATA_W = 32;

  // fixed widths of the request and result fields
  localparam int REQ_W  = 2;
  localparam int STAT_W = 2;
  localparam int IO_W   = 32;
  localparam int OCC_W  = 8;
  localparam int CFG_W  = 8;

  // count holds 0 .. DEPTH, compare width also covers the 8-bit register
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CAP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // cells per first-level gather group
  localparam int GRP  = 16;
  localparam int NGRP = (DEPTH + GRP - 1) / GRP;

  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_REAR  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_POP_REAR   = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

  typedef logic [DATA_W-1:0] word_t;

  typedef struct packed {
    logic clear;
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
  } cde_ctl_t;

endpackage

### sv/cde_cell.sv
// ----------------------------------------------------------------------------
// cde_cell: one slot of the deque row
// Holds a word and a valid bit; shifts towards either neighbour, takes a rear
// push when it is the first free cell and drops out when it is the last one.
// ----------------------------------------------------------------------------
module cde_cell (
  input  logic              clk,
  input  logic              rst,
  input  cde_pkg::cde_ctl_t ctl,
  input  cde_pkg::word_t    push_word,
  input  cde_pkg::word_t    left_word,
  input  logic              left_valid,
  input  cde_pkg::word_t    right_word,
  input  logic              right_valid,
  output cde_pkg::word_t    word,
  output logic              valid,
  output cde_pkg::word_t    rear_word
);
  import cde_pkg::*;

  logic is_last;

  assign is_last   = valid & ~right_valid;
  assign rear_word = is_last ? word : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.push_front) begin
      valid <= left_valid;
    end else if (ctl.push_rear) begin
      if (!valid && left_valid) begin
        valid <= 1'b1;
      end
    end else if (ctl.pop_front) begin
      valid <= right_valid;
    end else if (ctl.pop_rear) begin
      if (is_last) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push_front) begin
      word <= left_word;
    end else if (ctl.push_rear && !valid && left_valid) begin
      word <= push_word;
    end else if (ctl.pop_front) begin
      word <= right_word;
    end
  end

endmodule

### sv/cde_gather.sv
// ----------------------------------------------------------------------------
// cde_gather: rear word collection
// Registered first level of an OR tree over the masked cell words, followed
// by a small combinational OR over the group registers.
// ----------------------------------------------------------------------------
module cde_gather (
  input  logic           clk,
  input  cde_pkg::word_t cell_rear [cde_pkg::DEPTH],
  output cde_pkg::word_t rear_word
);
  import cde_pkg::*;

  word_t grp_or_next [NGRP];
  word_t grp_or      [NGRP];

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_or_next[g] = '0;
      for (int j = 0; j < GRP; j++) begin
        if (g * GRP + j < DEPTH) begin
          grp_or_next[g] = grp_or_next[g] | cell_rear[g * GRP + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGRP; g++) begin
      grp_or[g] <= grp_or_next[g];
    end
  end

  always_comb begin
    rear_word = '0;
    for (int g = 0; g < NGRP; g++) begin
      rear_word = rear_word | grp_or[g];
    end
  end

endmodule

### sv/circular_deque_core.sv
// ----------------------------------------------------------------------------
// circular_deque_core: double-ended queue in a row of cells
// Words sit left-justified in the cell row, front in cell 0. Capacity
// register sets the fullness limit; a write to it empties the deque.
// ----------------------------------------------------------------------------
//  channel   direction  signals                              transfer
//  request   in         start, busy, req_type, data_in       start & ~busy
//  config    in         cfg_valid, cfg_ready, cfg_data       cfg_valid & cfg_ready
//  result    out        done, status, data_out, occupancy    done, one cycle
//
// pushes, pop front and any overflow or underflow load the result registers at
// the accepting edge, so the result strobe follows it. pop rear first passes
// the last word through the registered gather tree in the gather state.
// busy is high in that gather state of a pop rear and while a capacity
// word is offered, so a request never meets a capacity write.
// rst clears the valid bits, the count, the capacity (to 128) and the strobe.
// results cannot be stalled; a new request may be taken while one is shown.
// ----------------------------------------------------------------------------
module circular_deque_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [cde_pkg::REQ_W-1:0]         req_type,
  input  logic signed [cde_pkg::IO_W-1:0]   data_in,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cde_pkg::CFG_W-1:0]         cfg_data,
  output logic                              done,
  output logic [cde_pkg::STAT_W-1:0]        status,
  output logic signed [cde_pkg::IO_W-1:0]   data_out,
  output logic [cde_pkg::OCC_W-1:0]         occupancy
);
  import cde_pkg::*;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_GATHER = 1'b1;

  logic state, state_next;
  logic [CFG_W-1:0] capacity;
  logic [CNT_W-1:0] count, count_next;

  logic              done_next;
  logic [STAT_W-1:0] status_next;
  logic [IO_W-1:0]   data_out_next;
  logic              load_result;

  cde_ctl_t ctl;
  word_t    push_word;
  word_t    rear_word;
  word_t    cell_word  [DEPTH];
  logic     cell_valid [DEPTH];
  word_t    cell_rear  [DEPTH];

  logic [CAP_W-1:0] cap_wide, cap_eff, count_wide, count_plus, count_minus;
  logic [63:0]      din_wide, front_wide, rear_wide;
  logic             accept, cfg_write, full, empty;

  assign busy      = (state == ST_GATHER) | cfg_valid;
  assign cfg_ready = (state == ST_IDLE);
  assign cfg_write = cfg_valid & cfg_ready;
  assign accept    = start & ~busy;

  assign din_wide   = 64'(unsigned'(data_in));
  assign push_word  = din_wide[DATA_W-1:0];
  assign front_wide = 64'(cell_word[0]);
  assign rear_wide  = 64'(rear_word);

  assign cap_wide    = CAP_W'(capacity);
  assign count_wide  = CAP_W'(count);
  assign count_plus  = count_wide + CAP_W'(1);
  assign count_minus = count_wide - CAP_W'(1);
  assign full        = (count_wide >= cap_eff);
  assign empty       = (count == '0);

  // zero means one slot, anything past the row means the whole row
  always_comb begin
    priority if (cap_wide == '0) begin
      cap_eff = CAP_W'(1);
    end else if (cap_wide > CAP_W'(DEPTH)) begin
      cap_eff = CAP_W'(DEPTH);
    end else begin
      cap_eff = cap_wide;
    end
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    ctl           = '0;
    done_next     = 1'b0;
    load_result   = 1'b0;
    status_next   = STAT_OK;
    data_out_next = '0;
    unique case (state)
      ST_IDLE: begin
        if (cfg_write) begin
          ctl.clear  = 1'b1;
          count_next = '0;
        end else if (accept) begin
          unique case (req_type)
            REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
              done_next   = 1'b1;
              load_result = 1'b1;
              if (full) begin
                status_next = STAT_OVERFLOW;
              end else begin
                ctl.push_front = (req_type == REQ_PUSH_FRONT);
                ctl.push_rear  = (req_type == REQ_PUSH_REAR);
                count_next     = count_plus[CNT_W-1:0];
              end
            end
            REQ_POP_FRONT: begin
              done_next   = 1'b1;
              load_result = 1'b1;
              if (empty) begin
                status_next = STAT_UNDERFLOW;
              end else begin
                ctl.pop_front = 1'b1;
                data_out_next = front_wide[IO_W-1:0];
                count_next    = count_minus[CNT_W-1:0];
              end
            end
            REQ_POP_REAR: begin
              if (empty) begin
                done_next   = 1'b1;
                load_result = 1'b1;
                status_next = STAT_UNDERFLOW;
              end else begin
                // group registers capture the last word at this edge
                state_next = ST_GATHER;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_GATHER: begin
        ctl.pop_rear  = 1'b1;
        done_next     = 1'b1;
        load_result   = 1'b1;
        data_out_next = rear_wide[IO_W-1:0];
        count_next    = count_minus[CNT_W-1:0];
        state_next    = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      capacity <= CFG_W'(128);
      done     <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
      if (cfg_write) begin
        capacity <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      status    <= status_next;
      data_out  <= signed'(data_out_next);
      occupancy <= OCC_W'(count_next);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t left_word, right_word;
    logic  left_valid, right_valid;

    if (i == 0) begin : g_first
      assign left_word  = push_word;
      assign left_valid = 1'b1;
    end else begin : g_inner_l
      assign left_word  = cell_word[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_word  = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner_r
      assign right_word  = cell_word[i+1];
      assign right_valid = cell_valid[i+1];
    end

    cde_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .push_word   (push_word),
      .left_word   (left_word),
      .left_valid  (left_valid),
      .right_word  (right_word),
      .right_valid (right_valid),
      .word        (cell_word[i]),
      .valid       (cell_valid[i]),
      .rear_word   (cell_rear[i])
    );
  end

  cde_gather u_gather (
    .clk       (clk),
    .cell_rear (cell_rear),
    .rear_word (rear_word)
  );

endmodule
